### rtl/voice_slot_allocator_with_stealing_core_defines.svh
// Assertion macros shared by the voice slot allocator RTL.
`ifndef VOICE_SLOT_ALLOCATOR_WITH_STEALING_CORE_DEFINES_SVH
`define VOICE_SLOT_ALLOCATOR_WITH_STEALING_CORE_DEFINES_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define VSA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define VSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/vsa_pkg.sv
// Types and constants shared by the voice slot allocator modules.
`timescale 1ns / 1ps
package vsa_pkg;

   localparam int MAX_VOICES = 128;
   localparam int SLOT_W     = 7;
   localparam int COUNT_W    = 8;
   localparam int AGE_W      = 64;
   localparam int LIMIT_W    = 8;
   localparam int OP_W       = 2;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd32;

   localparam logic [OP_W-1:0] OP_PLAY     = 2'd0;
   localparam logic [OP_W-1:0] OP_RELEASE  = 2'd1;
   localparam logic [OP_W-1:0] OP_SET_LOOP = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [SLOT_W-1:0] slot_index;
      logic              loop_flag;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic [SLOT_W-1:0]  granted_slot;
      logic               stole;
      logic [COUNT_W-1:0] live_voices;
   } rsp_type;

   typedef struct packed {
      logic             active;
      logic             looping;
      logic [AGE_W-1:0] age;
   } slot_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_PLAY,
      WR_RELEASE,
      WR_LOOP
   } wr_kind_type;

   typedef struct packed {
      wr_kind_type       kind;
      logic [SLOT_W-1:0] slot;
      logic              loop;
      logic [AGE_W-1:0]  age;
   } wr_cmd_type;

   typedef struct packed {
      logic [COUNT_W-1:0] live;
      logic               free_found;
      logic [SLOT_W-1:0]  free_slot;
      logic               best_found;
      logic [AGE_W-1:0]   best_age;
      logic [SLOT_W-1:0]  best_slot;
      logic               tgt_active;
   } scan_stats_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY
   } state_type;

endpackage

### rtl/voice_slot_allocator_with_stealing_core.sv
// Top level of the voice slot allocator with oldest one-shot stealing.
`timescale 1ns / 1ps
`include "voice_slot_allocator_with_stealing_core_defines.svh"

// The block handles one request at a time. It accepts the request, then the
// ring of slot cells rotates once past the scan unit (one slot per cycle), and
// finally the block applies the update and loads
// the response register. A waiting response does not block
// the next request from being accepted and scanned; only the final update
// waits until the response register is free. The voice limit register may be
// written only while no request is in flight.
module voice_slot_allocator_with_stealing_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  vsa_pkg::req_type            req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output vsa_pkg::rsp_type            rsp_payload,
   input  logic                        csr_write_enable,
   input  logic [vsa_pkg::LIMIT_W-1:0] csr_write_data
);
   import vsa_pkg::*;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] used_ff, used_in;
   logic [AGE_W-1:0]   start_counter_ff, start_counter_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;

   slot_type           ring [MAX_VOICES];
   wr_cmd_type         wr_cmd;
   scan_stats_type     stats;
   logic [SLOT_W-1:0]  scan_step;
   logic               scan_last;
   logic               scan_start;
   logic               scan_step_en;
   logic               req_fire;
   logic               apply_go;
   logic               in_range;
   logic               play_grant;

   assign req_ready    = (state_ff == ST_IDLE) && !reset;
   assign req_fire     = req_valid && req_ready;
   assign scan_start   = req_fire;
   assign scan_step_en = (state_ff == ST_SCAN);
   assign apply_go     = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_ready);
   assign in_range     = ({1'b0, req_ff.slot_index} < used_ff);

   for (genvar i = 0; i < MAX_VOICES; i++) begin : g_cell
      vsa_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_id    (SLOT_W'(i)),
         .shift_en   (scan_step_en),
         .shift_data (ring[(i + 1) % MAX_VOICES]),
         .wr_cmd     (wr_cmd),
         .entry      (ring[i])
      );
   end

   vsa_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .start      (scan_start),
      .step       (scan_step_en),
      .head       (ring[0]),
      .used       (used_ff),
      .target     (req_ff.slot_index),
      .stats      (stats),
      .step_index (scan_step),
      .last       (scan_last)
   );

   always_comb begin
      state_in         = state_ff;
      req_in           = req_ff;
      rsp_in           = rsp_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      used_in          = used_ff;
      start_counter_in = start_counter_ff;
      limit_in         = csr_write_enable ? csr_write_data : limit_ff;
      play_grant       = 1'b0;
      wr_cmd.kind      = WR_NONE;
      wr_cmd.slot      = req_ff.slot_index;
      wr_cmd.loop      = req_ff.loop_flag;
      wr_cmd.age       = start_counter_ff + 1'b1;

      rsp_in.accepted     = 1'b0;
      rsp_in.granted_slot = req_ff.slot_index;
      rsp_in.stole        = 1'b0;
      rsp_in.live_voices  = stats.live;

      case (req_ff.opcode)
         OP_PLAY: begin
            rsp_in.granted_slot = '0;
            if (stats.free_found) begin
               play_grant          = 1'b1;
               rsp_in.granted_slot = stats.free_slot;
            end else if ({1'b0, stats.live} < {1'b0, limit_ff} &&
                         used_ff < COUNT_W'(MAX_VOICES)) begin
               play_grant          = 1'b1;
               rsp_in.granted_slot = used_ff[SLOT_W-1:0];
            end else if (stats.best_found) begin
               play_grant          = 1'b1;
               rsp_in.granted_slot = stats.best_slot;
               rsp_in.stole        = 1'b1;
            end
            if (play_grant) begin
               rsp_in.accepted = 1'b1;
               wr_cmd.kind     = WR_PLAY;
               wr_cmd.slot     = rsp_in.granted_slot;
               if (!rsp_in.stole) begin
                  rsp_in.live_voices = stats.live + 1'b1;
               end
            end
         end
         OP_RELEASE: begin
            if (in_range) begin
               rsp_in.accepted    = 1'b1;
               wr_cmd.kind        = WR_RELEASE;
               rsp_in.live_voices = stats.live - {{(COUNT_W-1){1'b0}}, stats.tgt_active};
            end
         end
         OP_SET_LOOP: begin
            if (in_range) begin
               rsp_in.accepted = 1'b1;
               wr_cmd.kind     = WR_LOOP;
            end
         end
         default: begin
            rsp_in.accepted = 1'b0;
         end
      endcase

      if (!apply_go) begin
         wr_cmd.kind = WR_NONE;
         rsp_in      = rsp_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               req_in   = req_payload;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (apply_go) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (play_grant) begin
                  start_counter_in = start_counter_ff + 1'b1;
                  if (!stats.free_found && !rsp_in.stole) begin
                     used_in = used_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         used_ff          <= '0;
         start_counter_ff <= '0;
         limit_ff         <= LIMIT_RESET;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         used_ff          <= used_in;
         start_counter_ff <= start_counter_in;
         limit_ff         <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `VSA_ASSERT_NOW(a_ring_home, clock, reset, state_ff == ST_APPLY, scan_step == '0, "Slot ring is not back home when the update is applied.")
   `VSA_ASSERT_NEXT(a_counter_step, clock, reset, apply_go && play_grant, start_counter_ff == $past(start_counter_ff) + 1'b1, "Start counter did not advance on a granted play.")
   `VSA_ASSERT_NOW(a_live_bound, clock, reset, rsp_valid_ff, rsp_ff.live_voices <= used_ff, "Live voice count exceeds the number of opened slots.")
   `VSA_ASSERT_NOW(a_used_bound, clock, reset, 1'b1, used_ff <= COUNT_W'(MAX_VOICES), "Opened slot count exceeds the table size.")

endmodule

### rtl/vsa_cell.sv
// One voice slot cell of the rotating slot ring.
`timescale 1ns / 1ps
module vsa_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [vsa_pkg::SLOT_W-1:0] cell_id,
   input  logic                       shift_en,
   input  vsa_pkg::slot_type          shift_data,
   input  vsa_pkg::wr_cmd_type        wr_cmd,
   output vsa_pkg::slot_type          entry
);
   import vsa_pkg::*;

   logic             active_ff, active_in;
   logic             looping_ff, looping_in;
   logic [AGE_W-1:0] age_ff, age_in;
   logic             hit;

   assign hit = (wr_cmd.slot == cell_id);

   always_comb begin
      active_in  = active_ff;
      looping_in = looping_ff;
      age_in     = age_ff;
      if (shift_en) begin
         active_in  = shift_data.active;
         looping_in = shift_data.looping;
         age_in     = shift_data.age;
      end else if (hit) begin
         case (wr_cmd.kind)
            WR_PLAY: begin
               active_in  = 1'b1;
               looping_in = wr_cmd.loop;
               age_in     = wr_cmd.age;
            end
            WR_RELEASE: begin
               active_in = 1'b0;
            end
            WR_LOOP: begin
               looping_in = wr_cmd.loop;
            end
            default: begin
               active_in = active_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      looping_ff <= looping_in;
      age_ff     <= age_in;
   end

   assign entry.active  = active_ff;
   assign entry.looping = looping_ff;
   assign entry.age     = age_ff;

endmodule

### rtl/vsa_scan.sv
// Scan unit that gathers slot statistics from the head of the slot ring.
`timescale 1ns / 1ps
module vsa_scan (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        step,
   input  vsa_pkg::slot_type           head,
   input  logic [vsa_pkg::COUNT_W-1:0] used,
   input  logic [vsa_pkg::SLOT_W-1:0]  target,
   output vsa_pkg::scan_stats_type     stats,
   output logic [vsa_pkg::SLOT_W-1:0]  step_index,
   output logic                        last
);
   import vsa_pkg::*;

   logic [SLOT_W-1:0] step_ff, step_in;
   scan_stats_type    stats_ff, stats_in;
   logic              in_used;

   assign in_used = ({1'b0, step_ff} < used);

   always_comb begin
      step_in  = step_ff;
      stats_in = stats_ff;
      if (start) begin
         step_in  = '0;
         stats_in = '0;
      end else if (step) begin
         step_in       = step_ff + 1'b1;
         stats_in.live = stats_ff.live + {{(COUNT_W-1){1'b0}}, head.active};
         if (in_used && !head.active && !stats_ff.free_found) begin
            stats_in.free_found = 1'b1;
            stats_in.free_slot  = step_ff;
         end
         if (in_used && head.active && !head.looping &&
             (!stats_ff.best_found || (head.age < stats_ff.best_age))) begin
            stats_in.best_found = 1'b1;
            stats_in.best_age   = head.age;
            stats_in.best_slot  = step_ff;
         end
         if (step_ff == target) begin
            stats_in.tgt_active = head.active;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      stats_ff <= stats_in;
   end

   assign stats      = stats_ff;
   assign step_index = step_ff;
   assign last       = (step_ff == SLOT_W'(MAX_VOICES - 1));

endmodule

### bench/tb_top.sv
// Self-checking testbench for the voice slot allocator with oldest one-shot stealing.
`timescale 1ns / 1ps
module tb_top;
   import vsa_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int PRESSURE_AFTER  = 40;
   localparam int PRESSURE_CYCLES = 700;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int END_PAUSE       = 150;

   class voice_table_scoreboard;
      bit                   active [MAX_VOICES];
      bit                   looping [MAX_VOICES];
      bit [AGE_W-1:0]       age [MAX_VOICES];
      int unsigned          opened;
      bit [AGE_W-1:0]       play_count;
      bit [LIMIT_W-1:0]     limit;
      rsp_type              expected_q [$];
      int unsigned          failures;

      function new();
         foreach (active[i]) begin
            active[i] = 1'b0;
            looping[i] = 1'b0;
            age[i] = '0;
         end
         opened = 0;
         play_count = '0;
         limit = LIMIT_RESET;
         failures = 0;
      endfunction

      function void set_limit(bit [LIMIT_W-1:0] value);
         limit = value;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function int unsigned live_count();
         int unsigned n;
         n = 0;
         for (int i = 0; i < opened; i++)
            if (active[i])
               n++;
         return n;
      endfunction

      function void note_request(req_type r);
         rsp_type          e;
         int unsigned      live;
         bit               found;
         bit [AGE_W-1:0]   oldest;
         e = '0;
         e.granted_slot = r.slot_index;
         live = 0;
         found = 1'b0;
         oldest = '0;
         case (r.opcode)
            OP_PLAY: begin
               e.granted_slot = '0;
               for (int i = 0; i < opened; i++) begin
                  if (active[i]) begin
                     live++;
                  end else if (!found) begin
                     found = 1'b1;
                     e.granted_slot = SLOT_W'(i);
                  end
               end
               if (!found && live < limit && opened < MAX_VOICES) begin
                  found = 1'b1;
                  e.granted_slot = SLOT_W'(opened);
                  opened++;
               end
               if (!found) begin
                  for (int i = 0; i < opened; i++) begin
                     if (active[i] && !looping[i] && (!found || age[i] < oldest)) begin
                        found = 1'b1;
                        oldest = age[i];
                        e.granted_slot = SLOT_W'(i);
                     end
                  end
                  e.stole = found;
               end
               if (found) begin
                  play_count++;
                  age[e.granted_slot] = play_count;
                  active[e.granted_slot] = 1'b1;
                  looping[e.granted_slot] = r.loop_flag;
                  e.accepted = 1'b1;
               end
            end
            OP_RELEASE, OP_SET_LOOP: begin
               if (r.slot_index < opened) begin
                  e.accepted = 1'b1;
                  if (r.opcode == OP_RELEASE)
                     active[r.slot_index] = 1'b0;
                  else
                     looping[r.slot_index] = r.loop_flag;
               end
            end
            default: ;
         endcase
         e.live_voices = COUNT_W'(live_count());
         expected_q.push_back(e);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (expected_q.size() == 0) begin
            $error("response arrived with no request outstanding");
            failures++;
            return;
         end
         e = expected_q.pop_front();
         compare_field("accepted", 32'(e.accepted), 32'(got.accepted));
         compare_field("granted_slot", 32'(e.granted_slot), 32'(got.granted_slot));
         compare_field("stole", 32'(e.stole), 32'(got.stole));
         compare_field("live_voices", 32'(e.live_voices), 32'(got.live_voices));
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_payload = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_payload;
   logic                csr_write_enable = 1'b0;
   logic [LIMIT_W-1:0]  csr_write_data = '0;

   voice_table_scoreboard sb;
   bit tx_steady = 1'b0;
   bit rx_steady = 1'b0;
   bit pressure_done = 1'b0;
   int rsp_count = 0;
   int hold_left = 0;
   int idle_cycles = 0;

   voice_slot_allocator_with_stealing_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 90)
         return $urandom_range(1, 4);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_type make_request(logic [OP_W-1:0] op, int unsigned idx, bit lf);
      req_type r;
      r.opcode = op;
      r.slot_index = SLOT_W'(idx);
      r.loop_flag = lf;
      return r;
   endfunction

   function automatic req_type random_request();
      int unsigned pick;
      int unsigned idx;
      logic [OP_W-1:0] op;
      pick = $urandom_range(0, 99);
      if (pick < 50)
         op = OP_PLAY;
      else if (pick < 75)
         op = OP_RELEASE;
      else if (pick < 95)
         op = OP_SET_LOOP;
      else
         op = OP_UNUSED;
      if (sb.opened > 0 && $urandom_range(0, 9) != 0)
         idx = $urandom_range(0, sb.opened - 1);
      else
         idx = $urandom_range(0, MAX_VOICES - 1);
      return make_request(op, idx, $urandom_range(0, 3) == 0);
   endfunction

   task automatic send_request(input req_type r);
      int gap;
      gap = tx_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      wait_idle();
      csr_write_data <= value;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_limit(value);
   endtask

   task automatic run_phase(input logic [LIMIT_W-1:0] value, input int count);
      write_limit(value);
      tx_steady = ($urandom_range(0, 3) == 0);
      repeat (count)
         send_request(random_request());
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_payload);
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            rsp_count++;
         if ($urandom_range(0, 199) == 0)
            rx_steady = !rx_steady;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!pressure_done && rsp_count >= PRESSURE_AFTER) begin
            pressure_done = 1'b1;
            hold_left = PRESSURE_CYCLES;
            rsp_ready <= 1'b0;
         end else if (rx_steady || $urandom_range(0, 2) != 0) begin
            rsp_ready <= 1'b1;
         end else begin
            hold_left = pick_gap();
            rsp_ready <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Nothing is open yet; ops on unopened slots and the unused opcode are ignored.
      send_request(make_request(OP_RELEASE, 0, 1'b0));
      send_request(make_request(OP_SET_LOOP, MAX_VOICES - 1, 1'b1));
      send_request(make_request(OP_UNUSED, MAX_VOICES - 1, 1'b1));
      send_request(make_request(OP_PLAY, 0, 1'b0));
      send_request(make_request(OP_PLAY, MAX_VOICES - 1, 1'b1));
      send_request(make_request(OP_PLAY, 0, 1'b0));
      send_request(make_request(OP_SET_LOOP, 2, 1'b1));
      send_request(make_request(OP_SET_LOOP, 2, 1'b0));
      send_request(make_request(OP_RELEASE, 1, 1'b0));
      send_request(make_request(OP_UNUSED, 0, 1'b0));
      send_request(make_request(OP_PLAY, 5, 1'b0));
      send_request(make_request(OP_RELEASE, 3, 1'b1));

      // With a zero limit a play can only reuse a slot or steal, and it is dropped
      // when no opened slot is free and every live voice loops.
      write_limit(8'd0);
      send_request(make_request(OP_PLAY, 0, 1'b0));
      send_request(make_request(OP_SET_LOOP, 0, 1'b1));
      send_request(make_request(OP_SET_LOOP, 1, 1'b1));
      send_request(make_request(OP_SET_LOOP, 2, 1'b1));
      send_request(make_request(OP_PLAY, 0, 1'b0));
      send_request(make_request(OP_RELEASE, 2, 1'b0));
      send_request(make_request(OP_PLAY, 0, 1'b1));
      send_request(make_request(OP_PLAY, 0, 1'b0));
      write_limit(8'd1);
      send_request(make_request(OP_SET_LOOP, 1, 1'b0));
      send_request(make_request(OP_PLAY, 0, 1'b0));

      run_phase(8'd1, 40);
      run_phase(LIMIT_W'($urandom_range(2, 6)), 40);
      run_phase(8'd0, 40);
      run_phase(LIMIT_W'($urandom_range(8, 16)), 40);
      run_phase(LIMIT_W'($urandom_range(2, 40)), 40);

      // An out-of-range limit never restrains fresh slots, so plays fill the
      // whole table and then have to steal.
      write_limit(8'd255);
      tx_steady = 1'b0;
      while (sb.opened < MAX_VOICES)
         send_request(make_request(OP_PLAY, $urandom_range(0, MAX_VOICES - 1),
                                   $urandom_range(0, 7) == 0));
      repeat (15)
         send_request(make_request(OP_PLAY, $urandom_range(0, MAX_VOICES - 1),
                                   $urandom_range(0, 3) == 0));

      run_phase(8'd128, 45);
      run_phase(8'd1, 45);
      run_phase(LIMIT_W'($urandom_range(0, 255)), 45);
      run_phase(8'd255, 45);

      wait_idle();
      repeat (END_PAUSE) @(posedge clock);
      if (sb.failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/vsa_pkg.sv
rtl/vsa_cell.sv
rtl/vsa_scan.sv
rtl/voice_slot_allocator_with_stealing_core.sv
bench/tb_top.sv
